@@ src/tun_pkg.sv @@
`timescale 1ns / 1ps
package tun_pkg;

	localparam int M_W    = 31;
	localparam int SQ_W   = 64;
	localparam int ROOT_W = 32;
	localparam int REM_W  = 35;
	localparam int DEN_W  = 33;

	typedef struct packed {
		logic [2:0] neg;
		logic       degen;
	} ctl_t;

	typedef struct packed {
		logic [2:0][M_W-1:0] m;
		ctl_t                ctl;
	} sq_pl_t;

endpackage

@@ src/tun_tri_if.sv @@
`timescale 1ns / 1ps
interface tun_tri_if #(
	parameter int COORD_WIDTH = 16
);
	logic                          valid;
	logic                          ready;
	logic signed [COORD_WIDTH-1:0] p0_x;
	logic signed [COORD_WIDTH-1:0] p0_y;
	logic signed [COORD_WIDTH-1:0] p0_z;
	logic signed [COORD_WIDTH-1:0] p1_x;
	logic signed [COORD_WIDTH-1:0] p1_y;
	logic signed [COORD_WIDTH-1:0] p1_z;
	logic signed [COORD_WIDTH-1:0] p2_x;
	logic signed [COORD_WIDTH-1:0] p2_y;
	logic signed [COORD_WIDTH-1:0] p2_z;

	modport source (output valid, p0_x, p0_y, p0_z, p1_x, p1_y, p1_z, p2_x, p2_y, p2_z,
		input ready);
	modport sink (input valid, p0_x, p0_y, p0_z, p1_x, p1_y, p1_z, p2_x, p2_y, p2_z,
		output ready);
endinterface

@@ src/tun_nrm_if.sv @@
`timescale 1ns / 1ps
interface tun_nrm_if #(
	parameter int NORMAL_WIDTH = 16
);
	logic                           valid;
	logic                           ready;
	logic signed [NORMAL_WIDTH-1:0] normal_x;
	logic signed [NORMAL_WIDTH-1:0] normal_y;
	logic signed [NORMAL_WIDTH-1:0] normal_z;
	logic                           degenerate;

	modport source (output valid, normal_x, normal_y, normal_z, degenerate, input ready);
	modport sink (input valid, normal_x, normal_y, normal_z, degenerate, output ready);
endinterface

@@ src/tun_sqrt_cell.sv @@
`timescale 1ns / 1ps
module tun_sqrt_cell (
	input  logic                             clk,
	input  logic                             en,
	input  logic [tun_pkg::SQ_W-1:0]         rad,
	input  logic [tun_pkg::REM_W-1:0]        rem,
	input  logic [tun_pkg::ROOT_W-1:0]       root,
	input  tun_pkg::sq_pl_t                  pl,
	output logic [tun_pkg::SQ_W-1:0]         rad_q,
	output logic [tun_pkg::REM_W-1:0]        rem_q,
	output logic [tun_pkg::ROOT_W-1:0]       root_q,
	output tun_pkg::sq_pl_t                  pl_q
);
	logic [tun_pkg::REM_W-1:0] r2;
	logic [tun_pkg::REM_W-1:0] trial;
	logic                      ge;

	assign r2    = {rem[tun_pkg::REM_W-3:0], rad[tun_pkg::SQ_W-1 -: 2]};
	assign trial = {1'b0, root, 2'b01};
	assign ge    = r2 >= trial;

	always_ff @(posedge clk) begin
		if (en) begin
			rad_q  <= rad << 2;
			rem_q  <= ge ? r2 - trial : r2;
			root_q <= {root[tun_pkg::ROOT_W-2:0], ge};
			pl_q   <= pl;
		end
	end
endmodule

@@ src/tun_div_cell.sv @@
`timescale 1ns / 1ps
module tun_div_cell #(
	parameter int NORMAL_WIDTH = 16
) (
	input  logic                                 clk,
	input  logic                                 en,
	input  logic [tun_pkg::DEN_W-1:0]            den,
	input  logic [2:0][tun_pkg::DEN_W-1:0]       rem,
	input  logic [2:0][NORMAL_WIDTH-1:0]         lo,
	input  logic [2:0][NORMAL_WIDTH-1:0]         quo,
	input  tun_pkg::ctl_t                        ctl,
	output logic [tun_pkg::DEN_W-1:0]            den_q,
	output logic [2:0][tun_pkg::DEN_W-1:0]       rem_q,
	output logic [2:0][NORMAL_WIDTH-1:0]         lo_q,
	output logic [2:0][NORMAL_WIDTH-1:0]         quo_q,
	output tun_pkg::ctl_t                        ctl_q
);
	logic [2:0][tun_pkg::DEN_W:0] sh;
	logic [2:0]                   ge;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			sh[i] = {rem[i], lo[i][NORMAL_WIDTH-1]};
			ge[i] = sh[i] >= {1'b0, den};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				rem_q[i] <= ge[i] ? tun_pkg::DEN_W'(sh[i] - {1'b0, den})
					: sh[i][tun_pkg::DEN_W-1:0];
				lo_q[i]  <= lo[i] << 1;
				quo_q[i] <= {quo[i][NORMAL_WIDTH-2:0], ge[i]};
			end
			den_q <= den;
			ctl_q <= ctl;
		end
	end
endmodule

@@ src/triangle_unit_normal_3d.sv @@
`timescale 1ns / 1ps
// Unit face normal of a 3D triangle.
// vert (sink): one triangle per transfer, three points in signed fixed point.
// nrm (source): one result per triangle, normal components in signed Q1.15 at
// the default width, plus a degenerate flag (all components zero) when the
// cross product vanishes.
// Fully pipelined: while nrm is ready, one triangle accepted per cycle and
// one result per cycle. From input transfer to output valid the data passes
// 8 stages of edge, cross product, normalize and square-sum, a chain of 32
// square-root cells (one root bit each), one setup stage, a chain of
// NORMAL_WIDTH divider cells (one quotient bit each) and the output
// register.
// Each stage advances when it is empty or the stage after it advances, so
// bubbles collapse; when nrm stalls, vert keeps accepting until every stage
// holds an item. The output register holds its payload while stalled.
// Reset clears all stage valid bits; the pipeline is then empty and ready.
module triangle_unit_normal_3d #(
	parameter int COORD_WIDTH  = 16,
	parameter int NORMAL_WIDTH = 16
) (
	input logic      clk,
	input logic      arst_n,
	tun_tri_if.sink  vert,
	tun_nrm_if.source nrm
);
	localparam int CW   = COORD_WIDTH;
	localparam int NW   = NORMAL_WIDTH;
	localparam int F    = NW - 1;
	localparam int EW   = CW + 1;
	localparam int PW   = 2 * CW + 2;
	localparam int XW   = 2 * CW + 3;
	localparam int BW   = $clog2(XW + 1);
	localparam int MW   = tun_pkg::M_W;
	localparam int RW   = tun_pkg::ROOT_W;
	localparam int NUMW = NW + RW;
	localparam int SQ0  = 9;
	localparam int PR   = SQ0 + RW;
	localparam int DV0  = PR + 1;
	localparam int NST  = DV0 + NW;
	localparam logic [NW-1:0] NEG_MAX = {1'b1, {F{1'b0}}};
	localparam logic [NW-1:0] POS_MAX = {1'b0, {F{1'b1}}};

	logic [NST:1] v_q;
	logic [NST:1] en;

	always_comb begin
		en[NST] = !v_q[NST] || nrm.ready;
		for (int k = NST - 1; k >= 1; k--)
			en[k] = !v_q[k] || en[k+1];
	end

	assign vert.ready = en[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			if (en[1])
				v_q[1] <= vert.valid;
			for (int k = 2; k <= NST; k++)
				if (en[k])
					v_q[k] <= v_q[k-1];
		end
	end

	// edges
	logic signed [CW-1:0] p0 [3];
	logic signed [CW-1:0] p1 [3];
	logic signed [CW-1:0] p2 [3];
	logic signed [EW-1:0] e1_s1 [3];
	logic signed [EW-1:0] e2_s1 [3];

	assign p0[0] = vert.p0_x;
	assign p0[1] = vert.p0_y;
	assign p0[2] = vert.p0_z;
	assign p1[0] = vert.p1_x;
	assign p1[1] = vert.p1_y;
	assign p1[2] = vert.p1_z;
	assign p2[0] = vert.p2_x;
	assign p2[1] = vert.p2_y;
	assign p2[2] = vert.p2_z;

	always_ff @(posedge clk) begin
		if (en[1]) begin
			for (int i = 0; i < 3; i++) begin
				e1_s1[i] <= EW'(p1[i]) - EW'(p0[i]);
				e2_s1[i] <= EW'(p2[i]) - EW'(p0[i]);
			end
		end
	end

	// cross product
	logic signed [PW-1:0] pr_s2 [6];
	logic signed [XW-1:0] cr_s3 [3];

	always_ff @(posedge clk) begin
		if (en[2]) begin
			pr_s2[0] <= e1_s1[1] * e2_s1[2];
			pr_s2[1] <= e1_s1[2] * e2_s1[1];
			pr_s2[2] <= e1_s1[2] * e2_s1[0];
			pr_s2[3] <= e1_s1[0] * e2_s1[2];
			pr_s2[4] <= e1_s1[0] * e2_s1[1];
			pr_s2[5] <= e1_s1[1] * e2_s1[0];
		end
		if (en[3])
			for (int i = 0; i < 3; i++)
				cr_s3[i] <= XW'(pr_s2[2*i]) - XW'(pr_s2[2*i+1]);
	end

	// magnitudes, bit length, normalize to 31 bits
	logic [XW-1:0]      mag_s4 [3];
	logic [2:0]         neg_s4;
	logic [XW-1:0]      mag_s5 [3];
	logic [2:0]         neg_s5;
	logic [BW-1:0]      bl_s5;
	logic [XW-1:0]      orv;
	logic [BW-1:0]      bl;
	logic [XW+MW-1:0]   ext [3];
	tun_pkg::sq_pl_t    pl_s6;
	tun_pkg::sq_pl_t    pl_s7;
	tun_pkg::sq_pl_t    pl_s8;
	logic [2*MW-1:0]    sq_s7 [3];
	logic [tun_pkg::SQ_W-1:0] sum_s8;

	always_comb begin
		orv = mag_s4[0] | mag_s4[1] | mag_s4[2];
		bl  = '0;
		for (int b = 0; b < XW; b++)
			if (orv[b])
				bl = BW'(b + 1);
		for (int i = 0; i < 3; i++)
			ext[i] = {mag_s5[i], {MW{1'b0}}} >> bl_s5;
	end

	always_ff @(posedge clk) begin
		if (en[4]) begin
			for (int i = 0; i < 3; i++) begin
				neg_s4[i] <= cr_s3[i][XW-1];
				mag_s4[i] <= cr_s3[i][XW-1] ? XW'(-cr_s3[i]) : XW'(cr_s3[i]);
			end
		end
		if (en[5]) begin
			mag_s5 <= mag_s4;
			neg_s5 <= neg_s4;
			bl_s5  <= bl;
		end
		if (en[6]) begin
			for (int i = 0; i < 3; i++)
				pl_s6.m[i] <= ext[i][MW-1:0];
			pl_s6.ctl.neg   <= neg_s5;
			pl_s6.ctl.degen <= bl_s5 == '0;
		end
		if (en[7]) begin
			for (int i = 0; i < 3; i++)
				sq_s7[i] <= (2*MW)'(pl_s6.m[i]) * (2*MW)'(pl_s6.m[i]);
			pl_s7 <= pl_s6;
		end
		if (en[8]) begin
			sum_s8 <= tun_pkg::SQ_W'(sq_s7[0]) + tun_pkg::SQ_W'(sq_s7[1])
				+ tun_pkg::SQ_W'(sq_s7[2]);
			pl_s8  <= pl_s7;
		end
	end

	// square root chain
	logic [tun_pkg::SQ_W-1:0]  rad  [RW+1];
	logic [tun_pkg::REM_W-1:0] srem [RW+1];
	logic [RW-1:0]             root [RW+1];
	tun_pkg::sq_pl_t           spl  [RW+1];

	assign rad[0]  = sum_s8;
	assign srem[0] = '0;
	assign root[0] = '0;
	assign spl[0]  = pl_s8;

	for (genvar j = 0; j < RW; j++) begin : g_sqrt
		tun_sqrt_cell u_cell (
			.clk    (clk),
			.en     (en[SQ0+j]),
			.rad    (rad[j]),
			.rem    (srem[j]),
			.root   (root[j]),
			.pl     (spl[j]),
			.rad_q  (rad[j+1]),
			.rem_q  (srem[j+1]),
			.root_q (root[j+1]),
			.pl_q   (spl[j+1])
		);
	end

	// divider setup: numerator m * 2^(F+1) + L, divisor 2L
	logic [NUMW-1:0]                num [3];
	logic [tun_pkg::DEN_W-1:0]      den  [NW+1];
	logic [2:0][tun_pkg::DEN_W-1:0] drem [NW+1];
	logic [2:0][NW-1:0]             lo   [NW+1];
	logic [2:0][NW-1:0]             quo  [NW+1];
	tun_pkg::ctl_t                  ctl  [NW+1];

	always_comb begin
		for (int i = 0; i < 3; i++)
			num[i] = (NUMW'(spl[RW].m[i]) << NW) + NUMW'(root[RW]);
	end

	always_ff @(posedge clk) begin
		if (en[PR]) begin
			for (int i = 0; i < 3; i++) begin
				drem[0][i] <= tun_pkg::DEN_W'(num[i][NUMW-1:NW]);
				lo[0][i]   <= num[i][NW-1:0];
				quo[0][i]  <= '0;
			end
			den[0] <= {root[RW], 1'b0};
			ctl[0] <= spl[RW].ctl;
		end
	end

	for (genvar j = 0; j < NW; j++) begin : g_div
		tun_div_cell #(.NORMAL_WIDTH(NW)) u_cell (
			.clk   (clk),
			.en    (en[DV0+j]),
			.den   (den[j]),
			.rem   (drem[j]),
			.lo    (lo[j]),
			.quo   (quo[j]),
			.ctl   (ctl[j]),
			.den_q (den[j+1]),
			.rem_q (drem[j+1]),
			.lo_q  (lo[j+1]),
			.quo_q (quo[j+1]),
			.ctl_q (ctl[j+1])
		);
	end

	// sign, saturation, output register
	logic [NW-1:0] res [3];
	logic [NW-1:0] out_q [3];
	logic          degen_q;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (ctl[NW].degen)
				res[i] = '0;
			else if (ctl[NW].neg[i])
				res[i] = NW'(0) - ((quo[NW][i] > NEG_MAX) ? NEG_MAX : quo[NW][i]);
			else
				res[i] = (quo[NW][i] > POS_MAX) ? POS_MAX : quo[NW][i];
		end
	end

	always_ff @(posedge clk) begin
		if (en[NST]) begin
			out_q   <= res;
			degen_q <= ctl[NW].degen;
		end
	end

	assign nrm.valid      = v_q[NST];
	assign nrm.normal_x   = out_q[0];
	assign nrm.normal_y   = out_q[1];
	assign nrm.normal_z   = out_q[2];
	assign nrm.degenerate = degen_q;
endmodule

@@ src/tun_chk.sv @@
`timescale 1ns / 1ps
module tun_chk #(
	parameter int NORMAL_WIDTH = 16
) (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    out_valid,
	input logic                    out_ready,
	input logic [NORMAL_WIDTH-1:0] nx,
	input logic [NORMAL_WIDTH-1:0] ny,
	input logic [NORMAL_WIDTH-1:0] nz,
	input logic                    degen
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("output transfer dropped while stalled");

	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && degen |-> nx == '0 && ny == '0 && nz == '0)
		else $error("degenerate result with nonzero normal");

	a_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !degen |-> nx != '0 || ny != '0 || nz != '0)
		else $error("zero normal without degenerate flag");

	a_reset_empty: assert property (@(posedge clk)
		$rose(arst_n) |-> !out_valid)
		else $error("output valid right after reset");
endmodule

bind triangle_unit_normal_3d tun_chk #(.NORMAL_WIDTH(NORMAL_WIDTH)) u_tun_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (nrm.valid),
	.out_ready (nrm.ready),
	.nx        (nrm.normal_x),
	.ny        (nrm.normal_y),
	.nz        (nrm.normal_z),
	.degen     (nrm.degenerate)
);

@@ sim/tun_tb_if.sv @@
`timescale 1ns / 1ps
package tun_tb_pkg;

	typedef struct {
		logic signed [15:0] p [9];
	} tri_item_t;

	typedef struct {
		logic signed [15:0] nx;
		logic signed [15:0] ny;
		logic signed [15:0] nz;
		logic               degen;
	} nrm_item_t;

endpackage

@@ sim/triangle_unit_normal_3d_tb.sv @@
`timescale 1ns / 1ps
module triangle_unit_normal_3d_tb;

	localparam int LATENCY = 57;
	localparam int CYCLE_LIMIT = 400000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	tun_tri_if #(.COORD_WIDTH(16)) vert ();
	tun_nrm_if #(.NORMAL_WIDTH(16)) nrm ();

	triangle_unit_normal_3d #(.COORD_WIDTH(16), .NORMAL_WIDTH(16)) DUT (
		.clk(clk), .arst_n(arst_n), .vert(vert), .nrm(nrm)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	tun_tb_pkg::tri_item_t pending_tris[$];
	tun_tb_pkg::nrm_item_t expected_normals[$];
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	bit hold_send = 1'b0;
	bit in_taken = 1'b0;
	int mismatches = 0;
	int cycles = 0;

	function automatic logic [63:0] isqrt(logic [63:0] x);
		logic [63:0] r;
		logic [63:0] b;
		r = 0;
		b = 64'd1 << 62;
		while (b > x) b = b >> 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x = x - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic tun_tb_pkg::nrm_item_t face_normal(tun_tb_pkg::tri_item_t t);
		tun_tb_pkg::nrm_item_t n;
		logic signed [17:0] e1 [3];
		logic signed [17:0] e2 [3];
		logic signed [39:0] c [3];
		logic [39:0] mag [3];
		logic [63:0] m [3];
		logic [63:0] sum, len, q;
		logic signed [15:0] res [3];
		int blen;
		for (int i = 0; i < 3; i++) begin
			e1[i] = 18'(t.p[3 + i]) - 18'(t.p[i]);
			e2[i] = 18'(t.p[6 + i]) - 18'(t.p[i]);
		end
		c[0] = 40'(e1[1]) * 40'(e2[2]) - 40'(e1[2]) * 40'(e2[1]);
		c[1] = 40'(e1[2]) * 40'(e2[0]) - 40'(e1[0]) * 40'(e2[2]);
		c[2] = 40'(e1[0]) * 40'(e2[1]) - 40'(e1[1]) * 40'(e2[0]);
		blen = 0;
		for (int i = 0; i < 3; i++) begin
			mag[i] = c[i] < 0 ? -c[i] : c[i];
			for (int k = 0; k < 40; k++)
				if (mag[i][k] && k + 1 > blen) blen = k + 1;
		end
		n.degen = (blen == 0);
		if (blen == 0) begin
			n.nx = 0;
			n.ny = 0;
			n.nz = 0;
			return n;
		end
		for (int i = 0; i < 3; i++)
			m[i] = blen > 31 ? 64'(mag[i]) >> (blen - 31) : 64'(mag[i]) << (31 - blen);
		sum = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
		len = isqrt(sum);
		for (int i = 0; i < 3; i++) begin
			q = ((m[i] << 16) + len) / (2 * len);
			if (c[i] < 0) begin
				if (q > 32768) q = 32768;
				res[i] = 16'(-q);
			end else begin
				if (q > 32767) q = 32767;
				res[i] = 16'(q);
			end
		end
		n.nx = res[0];
		n.ny = res[1];
		n.nz = res[2];
		return n;
	endfunction

	function automatic logic signed [15:0] rand_coord(int mode);
		case (mode)
			0: return 16'($urandom);
			1: return 16'($urandom_range(0, 255)) - 16'sd128;
			2: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
			default: return 16'($urandom_range(0, 7)) - 16'sd4;
		endcase
	endfunction

	task automatic add_tri(logic signed [15:0] v [9]);
		tun_tb_pkg::tri_item_t t;
		for (int i = 0; i < 9; i++) t.p[i] = v[i];
		pending_tris.push_back(t);
	endtask

	// driver
	always @(negedge clk) begin
		tun_tb_pkg::tri_item_t t;
		if (!arst_n) begin
			vert.valid <= 1'b0;
		end else begin
			if (!vert.valid || in_taken) begin
				if (pending_tris.size() != 0 && !hold_send &&
						$urandom_range(0, 99) >= send_idle_pct) begin
					t = pending_tris[0];
					vert.valid <= 1'b1;
					vert.p0_x <= t.p[0];
					vert.p0_y <= t.p[1];
					vert.p0_z <= t.p[2];
					vert.p1_x <= t.p[3];
					vert.p1_y <= t.p[4];
					vert.p1_z <= t.p[5];
					vert.p2_x <= t.p[6];
					vert.p2_y <= t.p[7];
					vert.p2_z <= t.p[8];
				end else begin
					vert.valid <= 1'b0;
				end
			end
			nrm.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	// expectation capture at the transfer edge
	always @(posedge clk) begin
		tun_tb_pkg::tri_item_t t;
		in_taken = 1'b0;
		if (arst_n && vert.valid && vert.ready) begin
			in_taken = 1'b1;
			t.p[0] = vert.p0_x; t.p[1] = vert.p0_y; t.p[2] = vert.p0_z;
			t.p[3] = vert.p1_x; t.p[4] = vert.p1_y; t.p[5] = vert.p1_z;
			t.p[6] = vert.p2_x; t.p[7] = vert.p2_y; t.p[8] = vert.p2_z;
			expected_normals.push_back(face_normal(t));
			void'(pending_tris.pop_front());
		end
	end

	// monitor
	always @(posedge clk) begin
		tun_tb_pkg::nrm_item_t e;
		if (arst_n && nrm.valid && nrm.ready) begin
			if (expected_normals.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected normal transfer %0d %0d %0d %0b",
						nrm.normal_x, nrm.normal_y, nrm.normal_z, nrm.degenerate);
			end else begin
				e = expected_normals.pop_front();
				if (nrm.normal_x !== e.nx || nrm.normal_y !== e.ny ||
						nrm.normal_z !== e.nz || nrm.degenerate !== e.degen) begin
					mismatches++;
					if (mismatches <= 10)
						$display("normal mismatch exp %0d %0d %0d %0b got %0d %0d %0d %0b",
							e.nx, e.ny, e.nz, e.degen, nrm.normal_x, nrm.normal_y,
							nrm.normal_z, nrm.degenerate);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	task automatic drain();
		while (pending_tris.size() != 0 || vert.valid || expected_normals.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		logic signed [15:0] v [9];
		int mode;
		vert.valid = 1'b0;
		vert.p0_x = 0; vert.p0_y = 0; vert.p0_z = 0;
		vert.p1_x = 0; vert.p1_y = 0; vert.p1_z = 0;
		vert.p2_x = 0; vert.p2_y = 0; vert.p2_z = 0;
		nrm.ready = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: degenerate, axis normals, extremes, collinear
		v = '{default: 16'sd0}; add_tri(v);
		v = '{16'sd0, 16'sd0, 16'sd0, 16'sd256, 16'sd0, 16'sd0, 16'sd0, 16'sd256, 16'sd0};
		add_tri(v);
		v = '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd256, 16'sd0, 16'sd256, 16'sd0, 16'sd0};
		add_tri(v);
		v = '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd1, 16'sd0, 16'sd0, 16'sd0, 16'sd1};
		add_tri(v);
		v = '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd1, 16'sd1, 16'sd0, 16'sd0};
		add_tri(v);
		v = '{16'sd0, 16'sd0, 16'sd0, 16'sd1, 16'sd2, 16'sd3, 16'sd2, 16'sd4, 16'sd6};
		add_tri(v);
		v = '{16'sh8000, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh8000,
			16'sh8000, 16'sh7fff, 16'sh8000};
		add_tri(v);
		v = '{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh7fff,
			16'sh7fff, 16'sh8000, 16'sh7fff};
		add_tri(v);
		v = '{16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff,
			16'sh8000, 16'sh8000, 16'sh7fff};
		add_tri(v);
		v = '{16'sd5, 16'sd5, 16'sd5, 16'sd5, 16'sd5, 16'sd5, 16'sd9, 16'sd1, 16'sd3};
		add_tri(v);
		v = '{16'sd0, 16'sd0, 16'sd0, 16'sd1, 16'sd1, 16'sd0, 16'sd1, -16'sd1, 16'sd0};
		add_tri(v);
		v = '{16'sd0, 16'sd0, 16'sd0, 16'sd1, 16'sd0, 16'sd0, 16'sd1, 16'sd1, 16'sd1};
		add_tri(v);
		v = '{-16'sd1, -16'sd1, -16'sd1, 16'sh7fff, -16'sd1, -16'sd1,
			-16'sd1, -16'sd1, 16'sh7fff};
		add_tri(v);

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin send_idle_pct = 0; recv_stall_pct = 0; end
				1: begin send_idle_pct = 48; recv_stall_pct = 0; end
				2: begin send_idle_pct = 0; recv_stall_pct = 48; end
				default: begin send_idle_pct = 14; recv_stall_pct = 14; end
			endcase
			for (int n = 0; n < 475; n++) begin
				mode = $urandom_range(0, 3);
				for (int i = 0; i < 9; i++) v[i] = rand_coord(mode);
				if ($urandom_range(0, 19) == 0) begin
					v[3] = v[0]; v[4] = v[1]; v[5] = v[2];
				end
				add_tri(v);
			end
			while (pending_tris.size() != 0) @(posedge clk);
			if (ph == 1) begin
				hold_send = 1'b1;
				while (vert.valid || expected_normals.size() != 0) @(posedge clk);
				hold_send = 1'b0;
			end
		end
		drain();
		repeat (LATENCY + 10) @(posedge clk);
		if (mismatches == 0 && expected_normals.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
